>>> rtl/core/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB pixel converter.
// No dependencies; imported by every module of the converter core but the checker.
package hsv2rgb_pkg;

  // A full turn of hue splits into six 60-degree sectors
  localparam int HSV_SECTORS = 6;

  // Sector codes, named by the hues at their start and end
  typedef enum logic [2:0] {
    SECT_RED_YEL = 3'd0,
    SECT_YEL_GRN = 3'd1,
    SECT_GRN_CYN = 3'd2,
    SECT_CYN_BLU = 3'd3,
    SECT_BLU_MAG = 3'd4,
    SECT_MAG_RED = 3'd5
  } sector_t;

  // Control that travels down the pipe beside each word
  typedef struct packed {
    logic    valid;
    sector_t sector;
  } hsv_ctl_t;

endpackage

>>> rtl/core/hsv2rgb_front.sv
// Front end of the converter: hue wrap, sector and offset, chroma and span.
// Three register stages with a shared enable. Depends on hsv2rgb_pkg.
module hsv2rgb_front #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int CHANNEL_BITS  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [$clog2(360 << HUE_FRAC_BITS)-1:0] hue,
  input  logic [CHANNEL_BITS-1:0]               sat,
  input  logic [CHANNEL_BITS-1:0]               val,
  output hsv2rgb_pkg::hsv_ctl_t                 ctl,
  output logic [CHANNEL_BITS-1:0]               chroma,
  output logic [$clog2((60 << HUE_FRAC_BITS) + 1)-1:0] span,
  output logic [CHANNEL_BITS-1:0]               bright
);
  import hsv2rgb_pkg::*;

  localparam int N         = CHANNEL_BITS;
  localparam int SECTOR    = 60 << HUE_FRAC_BITS;
  localparam int FULL_TURN = SECTOR * HSV_SECTORS;
  localparam int HUE_W     = $clog2(FULL_TURN);
  localparam int SPAN_W    = $clog2(SECTOR + 1);
  localparam int CMAX      = (1 << N) - 1;
  localparam int HALF      = CMAX / 2;

  // stage 1: wrap hue, v*s
  logic             v1_r;
  logic [HUE_W-1:0] hue1_r;
  logic [HUE_W-1:0] hue1_nxt;
  logic [2*N-1:0]   prod1_r;
  logic [N-1:0]     val1_r;

  // stage 2: sector, offset, first quotient estimate
  hsv_ctl_t         ctl2_r;
  sector_t          sec2_nxt;
  logic [HUE_W-1:0] base2;
  logic [HUE_W-1:0] off2_full;
  logic [HUE_W-1:0] off2_r;
  logic [2*N-1:0]   num2;
  logic [2*N-1:0]   est2;
  logic [2*N-1:0]   num2_r;
  logic [N-1:0]     q2_r;
  logic [N-1:0]     val2_r;

  // stage 3: quotient correction, span for the secondary
  hsv_ctl_t          ctl3_r;
  logic [2*N-1:0]    rem3;
  logic              odd3;
  logic [N-1:0]      c3_nxt;
  logic [SPAN_W-1:0] span3_nxt;
  logic [N-1:0]      c3_r;
  logic [SPAN_W-1:0] span3_r;
  logic [N-1:0]      val3_r;

  // input range exceeds one turn by less than a turn
  assign hue1_nxt = (hue >= HUE_W'(FULL_TURN)) ? hue - HUE_W'(FULL_TURN) : hue;

  always_comb begin
    sec2_nxt = SECT_RED_YEL;
    base2    = '0;
    for (int k = 1; k < HSV_SECTORS; k++) begin
      if (hue1_r >= HUE_W'(k * SECTOR)) begin
        sec2_nxt = sector_t'(3'(k));
        base2    = HUE_W'(k * SECTOR);
      end
    end
    off2_full = hue1_r - base2;
  end

  // divide by 2^N-1: (n + n>>N) >> N lands on q or q-1
  assign num2 = prod1_r + (2*N)'(HALF);
  assign est2 = num2 + (num2 >> N);

  // remainder of the estimate; fits 2N bits mod 2^2N
  assign rem3   = num2_r - {q2_r, N'(0)} + {N'(0), q2_r};
  assign c3_nxt = (rem3 >= (2*N)'(CMAX)) ? q2_r + N'(1) : q2_r;
  assign odd3   = (ctl2_r.sector == SECT_YEL_GRN) || (ctl2_r.sector == SECT_CYN_BLU) ||
                  (ctl2_r.sector == SECT_MAG_RED);
  assign span3_nxt = odd3 ? SPAN_W'(SECTOR) - SPAN_W'(off2_r) : SPAN_W'(off2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (en) begin
      v1_r          <= in_valid;
      ctl2_r.valid  <= v1_r;
      ctl2_r.sector <= sec2_nxt;
      ctl3_r        <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue1_r  <= hue1_nxt;
      prod1_r <= sat * val;
      val1_r  <= val;
      off2_r  <= off2_full;
      num2_r  <= num2;
      q2_r    <= est2[2*N-1:N];
      val2_r  <= val1_r;
      c3_r    <= c3_nxt;
      span3_r <= span3_nxt;
      val3_r  <= val2_r;
    end
  end

  assign ctl    = ctl3_r;
  assign chroma = c3_r;
  assign span   = span3_r;
  assign bright = val3_r;

endmodule

>>> rtl/core/hsv2rgb_xcalc.sv
// Secondary component x = round(c * span / SECTOR) and floor m = v - c.
// Two register stages; division by SECTOR is a shift and a reciprocal multiply.
// Depends on hsv2rgb_pkg.
module hsv2rgb_xcalc #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int CHANNEL_BITS  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  hsv2rgb_pkg::hsv_ctl_t                 ctl_in,
  input  logic [CHANNEL_BITS-1:0]               chroma_in,
  input  logic [$clog2((60 << HUE_FRAC_BITS) + 1)-1:0] span_in,
  input  logic [CHANNEL_BITS-1:0]               bright_in,
  output hsv2rgb_pkg::hsv_ctl_t                 ctl,
  output logic [CHANNEL_BITS-1:0]               chroma,
  output logic [CHANNEL_BITS-1:0]               second,
  output logic [CHANNEL_BITS-1:0]               floor_m
);
  import hsv2rgb_pkg::*;

  localparam int N      = CHANNEL_BITS;
  localparam int SECTOR = 60 << HUE_FRAC_BITS;
  localparam int SPAN_W = $clog2(SECTOR + 1);
  localparam int P_W    = N + SPAN_W;
  localparam int SHIFT  = HUE_FRAC_BITS + 2;     // SECTOR = 15 << SHIFT
  localparam int Y_W    = N + 4;
  localparam int RSH    = N + 8;
  localparam int RECIP  = ((1 << RSH) + 14) / 15;
  localparam int R_W    = N + 5;

  hsv_ctl_t         ctl4_r;
  logic [P_W-1:0]   prod4_r;
  logic [N-1:0]     c4_r;
  logic [N-1:0]     m4_r;

  hsv_ctl_t         ctl5_r;
  logic [P_W-1:0]   sum5;
  logic [Y_W-1:0]   y5;
  logic [Y_W+R_W-1:0] prod5_r;
  logic [N-1:0]     c5_r;
  logic [N-1:0]     m5_r;

  // round half up, then the power-of-two part of SECTOR
  assign sum5 = prod4_r + P_W'(SECTOR / 2);
  assign y5   = Y_W'(sum5 >> SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else if (en) begin
      ctl4_r <= ctl_in;
      ctl5_r <= ctl4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod4_r <= chroma_in * span_in;
      c4_r    <= chroma_in;
      m4_r    <= (bright_in >= chroma_in) ? bright_in - chroma_in : '0;
      prod5_r <= y5 * R_W'(RECIP);
      c5_r    <= c4_r;
      m5_r    <= m4_r;
    end
  end

  assign ctl     = ctl5_r;
  assign chroma  = c5_r;
  assign second  = prod5_r[RSH +: N];
  assign floor_m = m5_r;

endmodule

>>> rtl/core/hsv_to_rgb_converter.sv
// HSV to RGB pixel converter, top level.
// Channels: input word (in_hue, in_saturation, in_brightness) under in_valid /
// in_stall; result word (out_red, out_green, out_blue) under out_valid /
// out_stall. A word moves on a clock edge with valid high and stall low.
// Hue is in 1/2^HUE_FRAC_BITS degree; hue at or past a full turn wraps.
// Saturation and brightness are fractions with all ones meaning 1.0.
// Throughput: one pixel per clock while out_stall holds no pending result.
// The six pipeline stages (hue wrap and v*s, sector and chroma estimate,
// chroma correction, c*span multiply, reciprocal multiply, sector mux and
// floor add) all advance on one enable; the last one registers the result word.
// When out_stall holds a pending result, the whole pipe freezes and in_stall
// rises in the same cycle; nothing is dropped or repeated, and gaps between
// words are kept, not squeezed out.
// Reset (rst_n low, synchronous) clears every valid bit; the pipe is empty
// and ready on the first clock after reset.
module hsv_to_rgb_converter #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int CHANNEL_BITS  = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [$clog2(360 << HUE_FRAC_BITS)-1:0] in_hue,
  input  logic [CHANNEL_BITS-1:0]                 in_saturation,
  input  logic [CHANNEL_BITS-1:0]                 in_brightness,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [CHANNEL_BITS-1:0]                 out_red,
  output logic [CHANNEL_BITS-1:0]                 out_green,
  output logic [CHANNEL_BITS-1:0]                 out_blue
);
  import hsv2rgb_pkg::*;

  localparam int N      = CHANNEL_BITS;
  localparam int SECTOR = 60 << HUE_FRAC_BITS;
  localparam int SPAN_W = $clog2(SECTOR + 1);
  localparam int CMAX   = (1 << N) - 1;

  logic              en;
  hsv_ctl_t          f_ctl;
  logic [N-1:0]      f_chroma;
  logic [SPAN_W-1:0] f_span;
  logic [N-1:0]      f_bright;
  hsv_ctl_t          x_ctl;
  logic [N-1:0]      x_chroma;
  logic [N-1:0]      x_second;
  logic [N-1:0]      x_floor;

  logic [N-1:0]      r_pre, g_pre, b_pre;
  logic [N:0]        r_sum, g_sum, b_sum;
  logic [N-1:0]      red_nxt, green_nxt, blue_nxt;
  logic              out_valid_r;
  logic [N-1:0]      out_red_r, out_green_r, out_blue_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  hsv2rgb_front #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_valid),
    .hue     (in_hue),
    .sat     (in_saturation),
    .val     (in_brightness),
    .ctl     (f_ctl),
    .chroma  (f_chroma),
    .span    (f_span),
    .bright  (f_bright)
  );

  hsv2rgb_xcalc #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_xcalc (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ctl_in   (f_ctl),
    .chroma_in(f_chroma),
    .span_in  (f_span),
    .bright_in(f_bright),
    .ctl      (x_ctl),
    .chroma   (x_chroma),
    .second   (x_second),
    .floor_m  (x_floor)
  );

  always_comb begin
    case (x_ctl.sector)
      SECT_RED_YEL: begin r_pre = x_chroma; g_pre = x_second; b_pre = '0;       end
      SECT_YEL_GRN: begin r_pre = x_second; g_pre = x_chroma; b_pre = '0;       end
      SECT_GRN_CYN: begin r_pre = '0;       g_pre = x_chroma; b_pre = x_second; end
      SECT_CYN_BLU: begin r_pre = '0;       g_pre = x_second; b_pre = x_chroma; end
      SECT_BLU_MAG: begin r_pre = x_second; g_pre = '0;       b_pre = x_chroma; end
      default:      begin r_pre = x_chroma; g_pre = '0;       b_pre = x_second; end
    endcase
    r_sum     = {1'b0, r_pre} + {1'b0, x_floor};
    g_sum     = {1'b0, g_pre} + {1'b0, x_floor};
    b_sum     = {1'b0, b_pre} + {1'b0, x_floor};
    red_nxt   = (r_sum > (N+1)'(CMAX)) ? N'(CMAX) : r_sum[N-1:0];
    green_nxt = (g_sum > (N+1)'(CMAX)) ? N'(CMAX) : g_sum[N-1:0];
    blue_nxt  = (b_sum > (N+1)'(CMAX)) ? N'(CMAX) : b_sum[N-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= x_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_red_r   <= red_nxt;
      out_green_r <= green_nxt;
      out_blue_r  <= blue_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

>>> rtl/core/hsv2rgb_checker.sv
// Port-level checks for hsv_to_rgb_converter, attached by bind.
// No package dependency; widths follow the converter's parameters.
module hsv2rgb_checker #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int CHANNEL_BITS  = 8
) (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_valid,
  input logic                                    in_stall,
  input logic [$clog2(360 << HUE_FRAC_BITS)-1:0] in_hue,
  input logic [CHANNEL_BITS-1:0]                 in_saturation,
  input logic [CHANNEL_BITS-1:0]                 in_brightness,
  input logic                                    out_valid,
  input logic                                    out_stall,
  input logic [CHANNEL_BITS-1:0]                 out_red,
  input logic [CHANNEL_BITS-1:0]                 out_green,
  input logic [CHANNEL_BITS-1:0]                 out_blue
);

  // a held result word keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green) &&
                               $stable(out_blue))
    else $error("result word changed while stalled");

  // input side stalls exactly when a pending result is held
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the held result");

  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an accepted word that meets no stall reaches out_valid
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall
      ##1 !in_stall |=> out_valid)
    else $error("result missing after pipeline latency");

  // zero saturation gives gray at the input brightness
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_saturation == '0) ##1 !in_stall ##1 !in_stall
      ##1 !in_stall ##1 !in_stall ##1 !in_stall
      |=> (out_red == $past(in_brightness, 6)) && (out_green == $past(in_brightness, 6)) &&
          (out_blue == $past(in_brightness, 6)))
    else $error("gray pixel not passed through");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker #(
  .HUE_FRAC_BITS(HUE_FRAC_BITS),
  .CHANNEL_BITS (CHANNEL_BITS)
) u_hsv2rgb_checker (.*);

>>> sim/hsv_to_rgb_converter_tb.sv
// Self-checking testbench for hsv_to_rgb_converter: drives HSV pixel words,
// predicts each RGB word and compares it field by field as it leaves the pipe.
// Depends on rtl/core/hsv2rgb_pkg.sv and rtl/core/hsv_to_rgb_converter.sv.
module hsv_to_rgb_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  localparam int HUE_FRAC_BITS = 6;
  localparam int CHANNEL_BITS  = 8;
  localparam int HUE_W         = $clog2(360 << HUE_FRAC_BITS);
  localparam longint unsigned SECTOR_LEN = 60 << HUE_FRAC_BITS;
  localparam longint unsigned FULL_TURN  = SECTOR_LEN * HSV_SECTORS;
  localparam longint unsigned CMAX       = (1 << CHANNEL_BITS) - 1;
  localparam int HUE_TOP       = int'(FULL_TURN) - 1;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } rgb_word_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [HUE_W-1:0]        in_hue = '0;
  logic [CHANNEL_BITS-1:0] in_saturation = '0;
  logic [CHANNEL_BITS-1:0] in_brightness = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CHANNEL_BITS-1:0] out_red;
  logic [CHANNEL_BITS-1:0] out_green;
  logic [CHANNEL_BITS-1:0] out_blue;

  rgb_word_t rgb_expect_q[$];
  int        err_count = 0;
  bit        idle_en = 1'b1;

  hsv_to_rgb_converter #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("hsv_to_rgb_converter: mismatch");
    $finish;
  end

  function automatic longint unsigned div_half_up(longint unsigned num,
                                                  longint unsigned den);
    return (num + den / 2) / den;
  endfunction

  function automatic rgb_word_t hsv_to_rgb_word(logic [HUE_W-1:0] hue,
                                                logic [CHANNEL_BITS-1:0] sat,
                                                logic [CHANNEL_BITS-1:0] bri);
    longint unsigned angle, chroma, offs, span, second, lift;
    longint unsigned r, g, b;
    sector_t         sect;
    rgb_word_t       res;
    angle  = longint'(hue) % FULL_TURN;  // hues past a full turn wrap
    chroma = div_half_up(longint'(bri) * longint'(sat), CMAX);
    sect   = sector_t'(angle / SECTOR_LEN);
    offs   = angle % SECTOR_LEN;
    // odd sectors ramp down, even sectors ramp up
    span   = ((angle / SECTOR_LEN) % 2 == 1) ? SECTOR_LEN - offs : offs;
    second = div_half_up(chroma * span, SECTOR_LEN);
    lift   = (longint'(bri) >= chroma) ? longint'(bri) - chroma : 0;
    case (sect)
      SECT_RED_YEL: begin r = chroma; g = second; b = 0;      end
      SECT_YEL_GRN: begin r = second; g = chroma; b = 0;      end
      SECT_GRN_CYN: begin r = 0;      g = chroma; b = second; end
      SECT_CYN_BLU: begin r = 0;      g = second; b = chroma; end
      SECT_BLU_MAG: begin r = second; g = 0;      b = chroma; end
      default:      begin r = chroma; g = 0;      b = second; end
    endcase
    r = (r + lift > CMAX) ? CMAX : r + lift;
    g = (g + lift > CMAX) ? CMAX : g + lift;
    b = (b + lift > CMAX) ? CMAX : b + lift;
    res.red   = r[CHANNEL_BITS-1:0];
    res.green = g[CHANNEL_BITS-1:0];
    res.blue  = b[CHANNEL_BITS-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [CHANNEL_BITS-1:0] got,
                                 logic [CHANNEL_BITS-1:0] want);
    $display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
    err_count++;
  endtask

  // One process checks results and records accepted words, so a pop always
  // sees the pushes of earlier edges.
  always @(posedge clk) begin
    rgb_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rgb_expect_q.size() == 0) begin
        $display("[%0t] result word with nothing expected", $time);
        err_count++;
      end else begin
        want = rgb_expect_q.pop_front();
        if (out_red !== want.red)     report_mismatch("red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("green", out_green, want.green);
        if (out_blue !== want.blue)   report_mismatch("blue", out_blue, want.blue);
      end
    end
    if (rst_n && in_valid && !in_stall)
      rgb_expect_q.push_back(hsv_to_rgb_word(in_hue, in_saturation, in_brightness));
  end

  always @(posedge clk) begin
    out_stall <= idle_en && ($urandom_range(99) < 13);
  end

  task automatic send_pixel(logic [HUE_W-1:0] hue, logic [CHANNEL_BITS-1:0] sat,
                            logic [CHANNEL_BITS-1:0] bri);
    while (idle_en && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_brightness <= bri;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_pipe_empty();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rgb_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_pixel();
    logic [HUE_W-1:0]        hue;
    logic [CHANNEL_BITS-1:0] sat, bri;
    hue = ($urandom_range(99) < 85) ? HUE_W'($urandom_range(HUE_TOP, 0))
                                    : HUE_W'($urandom);
    sat = CHANNEL_BITS'($urandom);
    bri = CHANNEL_BITS'($urandom);
    case ($urandom_range(9))
      0: sat = '1;
      1: bri = '1;
      2: sat = '0;
      default: ;
    endcase
    send_pixel(hue, sat, bri);
  endtask

  // Sector edges, wrap-around, gray, black and rounding midpoints
  task automatic test_directed();
    send_pixel(0, '1, '1);
    send_pixel(HUE_W'(SECTOR_LEN - 1), '1, '1);
    send_pixel(HUE_W'(SECTOR_LEN), '1, '1);
    send_pixel(HUE_W'(SECTOR_LEN * 2), '1, '1);
    send_pixel(HUE_W'(SECTOR_LEN * 3), '1, '1);
    send_pixel(HUE_W'(SECTOR_LEN * 4), '1, '1);
    send_pixel(HUE_W'(SECTOR_LEN * 5), '1, '1);
    send_pixel(HUE_W'(HUE_TOP), '1, '1);
    send_pixel(HUE_W'(FULL_TURN), '1, '1);
    send_pixel(HUE_W'(FULL_TURN + SECTOR_LEN + 7), 200, 180);
    send_pixel('1, '1, '1);
    send_pixel(HUE_W'(SECTOR_LEN / 2), 128, 200);
    send_pixel(HUE_W'(SECTOR_LEN * 3 / 2), '1, 128);
    send_pixel(5000, '0, 200);
    send_pixel(12345, '1, '0);
    send_pixel(9000, '0, '0);
    send_pixel(20000, 1, 1);
    send_pixel(17000, '1, 1);
    send_pixel(2, 1, '1);
    send_pixel(HUE_W'(SECTOR_LEN * 5 + 1), 127, 255);
  endtask

  task automatic test_random_pixels(int count);
    repeat (count) send_random_pixel();
  endtask

  // Back-to-back words with neither side holding off
  task automatic test_full_rate(int count);
    idle_en = 1'b0;
    repeat (count) send_random_pixel();
    idle_en = 1'b1;
  endtask

  task automatic test_drain_and_restart(int count);
    wait_pipe_empty();
    repeat (count) send_random_pixel();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_pixels(300);
    test_full_rate(250);
    test_drain_and_restart(100);
    test_random_pixels(250);
    wait_pipe_empty();
    repeat (12) @(posedge clk);
    if (err_count == 0) begin
      $display("hsv_to_rgb_converter: match");
    end else begin
      $display("hsv_to_rgb_converter: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv2rgb_front.sv
rtl/core/hsv2rgb_xcalc.sv
rtl/core/hsv_to_rgb_converter.sv
rtl/core/hsv2rgb_checker.sv
sim/hsv_to_rgb_converter_tb.sv
